@@ src/ecs_pkg.sv @@
package ecs_pkg;

	localparam int DEPTH  = 16;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int CODE_W = 32;
	localparam int OPC_W  = 3;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH     = 3'd0,
		OP_POP      = 3'd1,
		OP_CLEAR    = 3'd2,
		OP_CONTAINS = 3'd3,
		OP_GET      = 3'd4,
		OP_FLUSH    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_APPLY,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic rd_req;
		logic apply;
		logic walk_step;
		logic ld_res;
	} ecs_cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic idx_ok;
		logic ptr_last;
	} ecs_stat_t;

endpackage

@@ src/ecs_req_if.sv @@
interface ecs_req_if
	import ecs_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OPC_W-1:0]         opcode;
	logic signed [CODE_W-1:0] code;
	logic [IDX_W-1:0]         index;

	modport source (output valid, opcode, code, index, input ready);
	modport sink (input valid, opcode, code, index, output ready);
endinterface

@@ src/ecs_rsp_if.sv @@
interface ecs_rsp_if
	import ecs_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [CODE_W-1:0] code_out;
	logic [CNT_W-1:0]         count;

	modport source (output valid, ok, code_out, count, input ready);
	modport sink (input valid, ok, code_out, count, output ready);
endinterface

@@ src/ecs_ram.sv @@
module ecs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ src/ecs_dp.sv @@
module ecs_dp
	import ecs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ecs_cmd_t                 cmd,
	output ecs_stat_t                stat,
	input  logic [OPC_W-1:0]         req_opcode,
	input  logic signed [CODE_W-1:0] req_code,
	input  logic [IDX_W-1:0]         req_index,
	output logic                     rsp_ok,
	output logic signed [CODE_W-1:0] rsp_code_out,
	output logic [CNT_W-1:0]         rsp_count
);
	op_t               op_q;
	logic [CODE_W-1:0] code_q;
	logic [IDX_W-1:0]  index_q;
	logic [AW-1:0]     base_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     ptr_q;
	logic [CW-1:0]     dst_q;
	logic              ok_q;
	logic [CODE_W-1:0] val_q;
	logic              rsp_ok_q;
	logic [CODE_W-1:0] rsp_code_q;
	logic [CNT_W-1:0]  rsp_count_q;

	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     dst_next;
	logic [AW-1:0]     base_inc;
	logic [AW-1:0]     rd_lidx;
	logic              walk_op;
	logic              full;
	logic              hit;
	logic              push_wr;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CODE_W-1:0] ram_wdata;
	logic [CODE_W-1:0] ram_rdata;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [AW-1:0] l);
		logic [AW:0] sum;
		sum = {1'b0, b} + {1'b0, l};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign cnt_m1   = cnt_q - CW'(1);
	assign full     = (cnt_q == CW'(DEPTH));
	assign hit      = (ram_rdata == code_q);
	assign push_wr  = (cnt_q == '0) || !hit;
	assign dst_next = hit ? dst_q : dst_q + CW'(1);
	assign base_inc = (base_q == AW'(DEPTH - 1)) ? '0 : base_q + AW'(1);
	assign walk_op  = (op_q == OP_CONTAINS) || (op_q == OP_FLUSH);

	always_comb begin
		if (walk_op) begin
			rd_lidx = ptr_q;
		end else if (op_q == OP_GET) begin
			rd_lidx = index_q[AW-1:0];
		end else begin
			rd_lidx = cnt_m1[AW-1:0];
		end
	end

	assign ram_we    = (cmd.apply && op_q == OP_PUSH && push_wr)
	                || (cmd.walk_step && op_q == OP_FLUSH && !hit);
	assign ram_wdata = cmd.walk_step ? ram_rdata : code_q;

	always_comb begin
		if (cmd.walk_step) begin
			ram_waddr = phys(base_q, dst_q[AW-1:0]);
		end else if (full) begin
			ram_waddr = base_q;
		end else begin
			ram_waddr = phys(base_q, cnt_q[AW-1:0]);
		end
	end

	ecs_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_req),
		.raddr (phys(base_q, rd_lidx)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			base_q <= '0;
		end else begin
			if (cmd.apply) begin
				case (op_q)
					OP_PUSH: begin
						if (push_wr) begin
							if (full) begin
								base_q <= base_inc;
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
					end
					OP_POP:   cnt_q <= cnt_m1;
					OP_CLEAR: cnt_q <= '0;
					default:  ;
				endcase
			end
			if (cmd.walk_step && op_q == OP_FLUSH && stat.ptr_last) begin
				cnt_q <= dst_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= op_t'(req_opcode);
			code_q  <= req_code;
			index_q <= req_index;
			ok_q    <= 1'b0;
			val_q   <= '0;
			ptr_q   <= '0;
			dst_q   <= '0;
		end
		if (cmd.apply && (op_q == OP_POP || op_q == OP_GET)) begin
			ok_q  <= 1'b1;
			val_q <= ram_rdata;
		end
		if (cmd.walk_step) begin
			ptr_q <= ptr_q + AW'(1);
			dst_q <= dst_next;
			if (op_q == OP_CONTAINS && hit) begin
				ok_q <= 1'b1;
			end
		end
		if (cmd.ld_res) begin
			rsp_ok_q    <= ok_q;
			rsp_code_q  <= val_q;
			rsp_count_q <= CNT_W'(cnt_q);
		end
	end

	assign stat = '{
		op:       op_q,
		cnt_zero: (cnt_q == '0),
		idx_ok:   (CNT_W'(index_q) < CNT_W'(cnt_q)),
		ptr_last: (ptr_q == cnt_m1[AW-1:0])
	};

	assign rsp_ok       = rsp_ok_q;
	assign rsp_code_out = $signed(rsp_code_q);
	assign rsp_count    = rsp_count_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("count above depth");
	a_flush_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> dst_q <= CW'(ptr_q))
		else $error("flush write ahead of read");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && op_q == OP_POP) |-> cnt_q != '0)
		else $error("pop applied on empty stack");
	a_get_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && op_q == OP_GET) |-> $past(cmd.rd_req) && stat.idx_ok)
		else $error("get applied without a valid read");
`endif
endmodule

@@ src/ecs_ctrl.sv @@
module ecs_ctrl
	import ecs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  ecs_stat_t stat,
	output ecs_cmd_t  cmd
);
	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.op) inside
					OP_PUSH: begin
						cmd.rd_req = !stat.cnt_zero;
						state_d    = ST_APPLY;
					end
					OP_POP: begin
						cmd.rd_req = !stat.cnt_zero;
						state_d    = stat.cnt_zero ? ST_DONE : ST_APPLY;
					end
					OP_CLEAR: begin
						state_d = ST_APPLY;
					end
					OP_GET: begin
						cmd.rd_req = stat.idx_ok;
						state_d    = stat.idx_ok ? ST_APPLY : ST_DONE;
					end
					OP_CONTAINS, OP_FLUSH: begin
						state_d = stat.cnt_zero ? ST_DONE : ST_WALK_RD;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_WALK_RD: begin
				cmd.rd_req = 1'b1;
				state_d    = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				cmd.walk_step = 1'b1;
				state_d       = stat.ptr_last ? ST_DONE : ST_WALK_RD;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.ld_res = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
endmodule

@@ src/error_code_stack.sv @@
// channel  role  beat
// req      sink  opcode, code, index
// rsp      src   ok, code_out, count
//
// push, pop, get, clear: decode, apply, done states; an empty pop or an out-of-range get skips apply
// contains, flush: one ram read and one compare per entry
// reset clears the count, the ring base and the fsm; the entry ram is not cleared
// one result is held in the output register; the next beat is accepted and
// worked while it waits, and stalls in its last cycle until the register frees
module error_code_stack
	import ecs_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	ecs_req_if.sink      req,
	ecs_rsp_if.source    rsp
);
	ecs_cmd_t  cmd;
	ecs_stat_t stat;

	ecs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ecs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_opcode   (req.opcode),
		.req_code     (req.code),
		.req_index    (req.index),
		.rsp_ok       (rsp.ok),
		.rsp_code_out (rsp.code_out),
		.rsp_count    (rsp.count)
	);
endmodule
